// ----- design/trd_pkg.sv -----
// Shared types, codes and a helper function of the touch report decoder.
package trd_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;
  localparam int MAX_POINTS_DEF = 10;

  localparam logic [6:0] MAX_LEN       = 7'd64;
  localparam logic [6:0] HEADER_BYTES  = 7'd4;
  localparam logic [6:0] GESTURE_BYTE  = 7'd6;
  localparam logic [2:0] RECORD_LAST   = 3'd5;
  localparam logic [7:0] ID_MAX_POINT  = 8'h0A;
  localparam logic [7:0] ID_GESTURE    = 8'hF6;
  localparam logic [7:0] DONE_FINISHED = 8'h82;
  localparam logic [7:0] DONE_MORE     = 8'h00;

  // Status bit positions.
  localparam int LO_POINT = 0;
  localparam int LO_GEST  = 1;
  localparam int LO_AUX   = 3;
  localparam int HI_BIOS  = 6;
  localparam int HI_CPU   = 5;
  localparam int HI_RUN   = 3;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_REPORT = 2'd1,
    OP_DONE   = 2'd2
  } trd_opcode_t;

  typedef enum logic [1:0] {
    KIND_ACTION  = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_SUMMARY = 2'd2
  } trd_kind_t;

  typedef enum logic [2:0] {
    ACT_NONE           = 3'd0,
    ACT_CPU_START      = 3'd1,
    ACT_POINT_MODE     = 3'd2,
    ACT_CLEAR          = 3'd3,
    ACT_READ_REPORT    = 3'd4,
    ACT_READ_REMAINDER = 3'd5
  } trd_action_t;

  typedef enum logic [1:0] {
    PEN_NONE = 2'd0,
    PEN_DOWN = 2'd1,
    PEN_UP   = 2'd2
  } trd_pen_t;

  typedef struct packed {
    trd_kind_t   kind;
    trd_action_t action;
    logic [7:0]  point_id;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [7:0]  point_weight;
    logic [3:0]  touch_count;
    logic [2:0]  gesture_code;
    trd_pen_t    pen_event;
    logic [11:0] event_x;
    logic [11:0] event_y;
    logic        last;
  } trd_result_t;

  // Up to two results leave the decoder for one item, res0 first.
  typedef struct packed {
    logic [1:0]  cnt;
    trd_result_t res0;
    trd_result_t res1;
  } trd_push_t;

  // Number of six-byte records after the header; len is already clamped to 64.
  // (len - 4) * 43 / 256 equals (len - 4) / 6 for every value up to 60.
  function automatic logic [3:0] packet_count(input logic [6:0] len);
    logic [11:0] prod;
    prod = 12'(len - HEADER_BYTES) * 12'd43;
    packet_count = (len >= HEADER_BYTES) ? prod[11:8] : 4'd0;
  endfunction

endpackage

// ----- design/trd_core.sv -----
// Input register, packet state and per-item decode of the touch report decoder.
module trd_core #(
  parameter int MAX_POINTS = trd_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [trd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           room,
  output trd_pkg::trd_push_t             push
);
  import trd_pkg::*;

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [7:0]  s1_lo_r, s1_hi_r, s1_byte_r;
  logic [15:0] s1_len_r;
  logic        fire;

  logic        pkt_active_r, pkt_active_nxt;
  logic [6:0]  byte_idx_r, byte_idx_nxt;
  logic [6:0]  pkt_len_r, pkt_len_nxt;
  logic [3:0]  pkt_cnt_r, pkt_cnt_nxt;
  logic        flag_pt_r, flag_pt_nxt;
  logic        flag_ge_r, flag_ge_nxt;
  logic [7:0]  rec_bytes_r [5];
  logic [7:0]  rec_bytes_nxt [5];
  logic [2:0]  off_r, off_nxt;
  logic [3:0]  rec_r, rec_nxt;
  logic [7:0]  first_id_r, first_id_nxt;
  logic [11:0] first_x_r, first_x_nxt;
  logic [11:0] first_y_r, first_y_nxt;
  logic [7:0]  first_w_r, first_w_nxt;
  logic [2:0]  gest_r, gest_nxt;
  logic        pen_down_r, pen_down_nxt;

  trd_action_t act;
  logic        is_point;
  logic [6:0]  len_clamped;
  logic [11:0] pt_x, pt_y;
  logic [3:0]  cnt_capped;

  assign fire      = s1_valid_r && room;
  assign in_tready = !s1_valid_r || room;

  assign is_point    = (first_id_r <= ID_MAX_POINT) && flag_pt_r;
  assign len_clamped = (s1_len_r > 16'(MAX_LEN)) ? MAX_LEN : s1_len_r[6:0];
  assign pt_x        = {rec_bytes_r[3][7:4], rec_bytes_r[1]};
  assign pt_y        = {rec_bytes_r[3][3:0], rec_bytes_r[2]};
  assign cnt_capped  = (pkt_cnt_r > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : pkt_cnt_r;

  // Command action from a status word, highest priority first, or from a packet-done byte.
  always_comb begin
    act = ACT_NONE;
    if (s1_op_r == OP_DONE) begin
      if (s1_lo_r == DONE_FINISHED) begin
        act = ACT_CLEAR;
      end else if (s1_lo_r == DONE_MORE) begin
        act = ACT_READ_REMAINDER;
      end
    end else begin
      priority if (s1_hi_r[HI_BIOS]) begin
        act = ACT_CPU_START;
      end else if (s1_hi_r[HI_CPU]) begin
        act = ACT_POINT_MODE;
      end else if (s1_hi_r[HI_RUN] && s1_len_r == 16'd0) begin
        act = ACT_CLEAR;
      end else if (s1_lo_r[LO_POINT] || s1_lo_r[LO_GEST]) begin
        act = ACT_READ_REPORT;
      end else if (s1_hi_r[HI_RUN] && s1_lo_r[LO_AUX]) begin
        act = ACT_CLEAR;
      end
    end
  end

  always_comb begin
    pkt_active_nxt = pkt_active_r;
    byte_idx_nxt   = byte_idx_r;
    pkt_len_nxt    = pkt_len_r;
    pkt_cnt_nxt    = pkt_cnt_r;
    flag_pt_nxt    = flag_pt_r;
    flag_ge_nxt    = flag_ge_r;
    rec_bytes_nxt  = rec_bytes_r;
    off_nxt        = off_r;
    rec_nxt        = rec_r;
    first_id_nxt   = first_id_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    first_w_nxt    = first_w_r;
    gest_nxt       = gest_r;
    pen_down_nxt   = pen_down_r;
    push           = '0;

    if (fire) begin
      unique case (s1_op_r)
        OP_STATUS: begin
          pkt_active_nxt = 1'b0;
          if (act == ACT_READ_REPORT) begin
            pkt_active_nxt = 1'b1;
            byte_idx_nxt   = '0;
            pkt_len_nxt    = len_clamped;
            pkt_cnt_nxt    = packet_count(len_clamped);
            flag_pt_nxt    = s1_lo_r[LO_POINT];
            flag_ge_nxt    = s1_lo_r[LO_GEST];
            off_nxt        = '0;
            rec_nxt        = '0;
            first_id_nxt   = '0;
            first_x_nxt    = '0;
            first_y_nxt    = '0;
            first_w_nxt    = '0;
            gest_nxt       = '0;
          end
          push.cnt         = 2'd1;
          push.res0.kind   = KIND_ACTION;
          push.res0.action = act;
          push.res0.last   = 1'b1;
        end
        OP_REPORT: begin
          if (pkt_active_r && byte_idx_r < pkt_len_r) begin
            byte_idx_nxt = byte_idx_r + 7'd1;
            if (byte_idx_r == HEADER_BYTES) begin
              first_id_nxt = s1_byte_r;
            end
            if (byte_idx_r == GESTURE_BYTE) begin
              gest_nxt = s1_byte_r[2:0];
            end
            if (byte_idx_r >= HEADER_BYTES) begin
              for (int i = 0; i < 5; i++) begin
                if (off_r == 3'(i)) begin
                  rec_bytes_nxt[i] = s1_byte_r;
                end
              end
              if (off_r == RECORD_LAST) begin
                off_nxt = '0;
                rec_nxt = rec_r + 4'd1;
                if (is_point && rec_r < pkt_cnt_r) begin
                  if (rec_r == 4'd0) begin
                    first_x_nxt = pt_x;
                    first_y_nxt = pt_y;
                    first_w_nxt = rec_bytes_r[4];
                  end
                  if (rec_r < 4'(MAX_POINTS)) begin
                    push.cnt               = 2'd1;
                    push.res0.kind         = KIND_POINT;
                    push.res0.point_id     = rec_bytes_r[0];
                    push.res0.point_x      = pt_x;
                    push.res0.point_y      = pt_y;
                    push.res0.point_weight = rec_bytes_r[4];
                    push.res0.last         = 1'b1;
                  end
                end
              end else begin
                off_nxt = off_r + 3'd1;
              end
            end
          end
        end
        OP_DONE: begin
          if (pkt_active_r) begin
            pkt_active_nxt = 1'b0;
            push.cnt       = 2'd2;
            push.res0.kind = KIND_SUMMARY;
            if (is_point) begin
              push.res0.touch_count = cnt_capped;
              if (first_w_r != 8'd0 && !pen_down_r) begin
                pen_down_nxt        = 1'b1;
                push.res0.pen_event = PEN_DOWN;
                push.res0.event_x   = first_x_r;
                push.res0.event_y   = first_y_r;
              end else if (first_w_r == 8'd0 && pen_down_r) begin
                pen_down_nxt        = 1'b0;
                push.res0.pen_event = PEN_UP;
                push.res0.event_x   = first_x_r;
                push.res0.event_y   = first_y_r;
              end
            end else if (first_id_r == ID_GESTURE && flag_ge_r) begin
              pen_down_nxt           = 1'b0;
              push.res0.gesture_code = gest_r;
            end
            push.res1.kind   = KIND_ACTION;
            push.res1.action = act;
            push.res1.last   = 1'b1;
          end else begin
            push.cnt         = 2'd1;
            push.res0.kind   = KIND_ACTION;
            push.res0.action = act;
            push.res0.last   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pkt_active_r <= 1'b0;
      byte_idx_r   <= '0;
      pkt_len_r    <= '0;
      pkt_cnt_r    <= '0;
      flag_pt_r    <= 1'b0;
      flag_ge_r    <= 1'b0;
      off_r        <= '0;
      rec_r        <= '0;
      first_id_r   <= '0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      first_w_r    <= '0;
      gest_r       <= '0;
      pen_down_r   <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      pkt_active_r <= pkt_active_nxt;
      byte_idx_r   <= byte_idx_nxt;
      pkt_len_r    <= pkt_len_nxt;
      pkt_cnt_r    <= pkt_cnt_nxt;
      flag_pt_r    <= flag_pt_nxt;
      flag_ge_r    <= flag_ge_nxt;
      off_r        <= off_nxt;
      rec_r        <= rec_nxt;
      first_id_r   <= first_id_nxt;
      first_x_r    <= first_x_nxt;
      first_y_r    <= first_y_nxt;
      first_w_r    <= first_w_nxt;
      gest_r       <= gest_nxt;
      pen_down_r   <= pen_down_nxt;
    end
  end

  // Item payload and record bytes need no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_lo_r   <= in_tdata[7:0];
      s1_hi_r   <= in_tdata[15:8];
      s1_len_r  <= in_tdata[31:16];
      s1_byte_r <= in_tdata[39:32];
    end
    rec_bytes_r <= rec_bytes_nxt;
  end

  a_idx_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= pkt_len_r)
    else $error("byte index ran past the packet length");

  a_read_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_op_r == OP_STATUS && act == ACT_READ_REPORT) |=> pkt_active_r)
    else $error("read report action did not open a packet");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.res0.kind == KIND_SUMMARY && !push.res0.last
                            && push.res1.kind == KIND_ACTION && push.res1.last))
    else $error("two-result item not summary then action");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r)
    else $error("input stalled with an empty input register");

endmodule

// ----- design/trd_out_queue.sv -----
// Three-entry result queue that parts the decoder from the output channel.
module trd_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  trd_pkg::trd_push_t     push,
  output logic                   room,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output trd_pkg::trd_result_t   head
);
  import trd_pkg::*;

  logic [1:0]  cnt_r, cnt_nxt, base;
  logic        pop;
  trd_result_t q_r [3];
  trd_result_t q_nxt [3];

  assign out_tvalid = (cnt_r != 2'd0);
  assign head       = q_r[0];
  assign pop        = out_tvalid && out_tready;
  assign base       = cnt_r - {1'b0, pop};
  // Room for the worst case of two results after this cycle's pop.
  assign room       = (base <= 2'd1);
  assign cnt_nxt    = base + push.cnt;

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push.cnt != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = push.res0;
      end
      if (push.cnt == 2'd2 && (base + 2'd1) == 2'(i)) begin
        q_nxt[i] = push.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("result pushed without room");

  a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && push.cnt == 2'd2) |=> (cnt_r == 2'd2))
    else $error("result pair not both queued");

  a_summary_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && head.kind == KIND_SUMMARY) |-> !head.last)
    else $error("summary result flagged as last");

endmodule

// ----- design/touch_report_decoder_unit.sv -----
// Top level of the touch report decoder: ports, decoder and result queue.
//
// Decodes touch controller status words, report packet bytes and packet-done
// bytes, selected by in_tuser. One item is accepted per cycle while the result
// queue has room. Each accepted item is held in the input register, and its
// results are written into a three-entry result queue whose head drives the
// output. A packet-done byte that closes an open packet gives two results (a
// packet summary, then the action), which leave as separate output transfers.
// The queue keeps accepting items as long as it can hold two more results
// after the current output transfer. Report bytes and items that give no
// result still pass through the input register and wait there while the queue has no room.
module touch_report_decoder_unit #(
  parameter int MAX_POINTS = trd_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // low_status[7:0], high_status[15:8], report_length[31:16], report_byte[39:32]
  input  logic [trd_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // action[2:0], point_id[10:3], point_x[22:11], point_y[34:23],
  // point_weight[42:35], touch_count[46:43], gesture_code[49:47],
  // pen_event[51:50], event_x[63:52], event_y[75:64], zero[79:76]
  output logic [trd_pkg::OUT_DATA_W-1:0] out_tdata,
  // result_kind[1:0]
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);
  import trd_pkg::*;

  trd_push_t   push;
  trd_result_t head;
  logic        room;

  trd_core #(
    .MAX_POINTS(MAX_POINTS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .room     (room),
    .push     (push)
  );

  trd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .head      (head)
  );

  assign out_tdata = {4'd0, head.event_y, head.event_x, head.pen_event, head.gesture_code,
                      head.touch_count, head.point_weight, head.point_y, head.point_x,
                      head.point_id, head.action};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ----- dv/touch_report_decoder_unit_test.sv -----
// Self-checking testbench of the touch report decoder with a built-in decode predictor.
module touch_report_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import trd_pkg::*;

  localparam int POINT_LIMIT  = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 1850;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int NUM_ROWS     = 24;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result fields as they sit in out_tdata, lowest field last.
  typedef struct packed {
    logic [3:0]  pad;
    logic [11:0] event_y;
    logic [11:0] event_x;
    trd_pen_t    pen;
    logic [2:0]  gesture;
    logic [3:0]  count;
    logic [7:0]  weight;
    logic [11:0] py;
    logic [11:0] px;
    logic [7:0]  pid;
    trd_action_t action;
  } result_word_t;

  typedef struct {
    trd_kind_t    kind;
    result_word_t word;
    logic         last;
  } decoded_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] len;
    logic [7:0]  rbyte;
    bit          typed;
    trd_action_t act;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  touch_report_decoder_unit #(.MAX_POINTS(POINT_LIMIT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  decoded_t  pending_results[$];
  plan_row_t plan [NUM_ROWS];
  int        errors      = 0;
  int        cycle_count = 0;
  int        random_used = 0;
  bit        steady      = 1'b0;

  // Predictor state.
  bit          pkt_open;
  logic [6:0]  byte_idx;
  logic [6:0]  pkt_len;
  bit          pt_flag;
  bit          ge_flag;
  logic [7:0]  rec_bytes [6];
  logic [7:0]  first_id;
  logic [31:0] first_pt;
  logic [2:0]  gest;
  bit          pen_is_down;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic decoded_t blank_result(trd_kind_t k, logic l);
    decoded_t r;
    r.kind = k;
    r.word = '0;
    r.last = l;
    return r;
  endfunction

  function automatic decoded_t action_result(trd_action_t a);
    decoded_t r;
    r = blank_result(KIND_ACTION, 1'b1);
    r.word.action = a;
    return r;
  endfunction

  function automatic int records_in_packet();
    return (pkt_len >= 4) ? (int'(pkt_len) - 4) / 6 : 0;
  endfunction

  function automatic bit is_point_report();
    return first_id <= ID_MAX_POINT && pt_flag;
  endfunction

  task automatic reset_predictor();
    pkt_open = 1'b0;
    byte_idx = '0;
    pkt_len = '0;
    pt_flag = 1'b0;
    ge_flag = 1'b0;
    foreach (rec_bytes[i]) rec_bytes[i] = '0;
    first_id = '0;
    first_pt = '0;
    gest = '0;
    pen_is_down = 1'b0;
  endtask

  // Updates the predictor for one accepted item and, when keep is set, queues its results.
  task automatic decode_item(input logic [1:0] op, input logic [IN_DATA_W-1:0] data,
                             input bit keep, output bit used);
    logic [7:0]  lo, hi, b;
    logic [15:0] len;
    logic [11:0] x, y;
    logic [7:0]  w;
    int          idx, off, recn, cnt;
    trd_action_t act;
    decoded_t    r;
    lo = data[7:0];
    hi = data[15:8];
    len = data[31:16];
    b = data[39:32];
    used = 1'b0;
    case (op)
      OP_STATUS: begin
        used = 1'b1;
        act = ACT_NONE;
        pkt_open = 1'b0;
        if (hi[HI_BIOS]) begin
          act = ACT_CPU_START;
        end else if (hi[HI_CPU]) begin
          act = ACT_POINT_MODE;
        end else if (hi[HI_RUN] && len == 0) begin
          act = ACT_CLEAR;
        end else if (lo[LO_POINT] || lo[LO_GEST]) begin
          act = ACT_READ_REPORT;
          pkt_open = 1'b1;
          byte_idx = '0;
          pkt_len = (len > MAX_LEN) ? MAX_LEN : len[6:0];
          pt_flag = lo[LO_POINT];
          ge_flag = lo[LO_GEST];
          foreach (rec_bytes[i]) rec_bytes[i] = '0;
          first_id = '0;
          first_pt = '0;
          gest = '0;
        end else if (hi[HI_RUN] && lo[LO_AUX]) begin
          act = ACT_CLEAR;
        end
        if (keep) pending_results.push_back(action_result(act));
      end
      OP_REPORT: begin
        if (pkt_open && byte_idx < pkt_len) begin
          used = 1'b1;
          idx = byte_idx;
          byte_idx = byte_idx + 7'd1;
          if (idx == 4) first_id = b;
          if (idx == 6) gest = b[2:0];
          if (idx >= 4) begin
            off = (idx - 4) % 6;
            recn = (idx - 4) / 6;
            rec_bytes[off] = b;
            if (off == 5 && is_point_report() && recn < records_in_packet()) begin
              x = {rec_bytes[3][7:4], rec_bytes[1]};
              y = {rec_bytes[3][3:0], rec_bytes[2]};
              w = rec_bytes[4];
              if (recn == 0) first_pt = {w, y, x};
              if (recn < POINT_LIMIT && keep) begin
                r = blank_result(KIND_POINT, 1'b1);
                r.word.pid = rec_bytes[0];
                r.word.px = x;
                r.word.py = y;
                r.word.weight = w;
                pending_results.push_back(r);
              end
            end
          end
        end
      end
      OP_DONE: begin
        used = 1'b1;
        act = (lo == DONE_FINISHED) ? ACT_CLEAR : (lo == DONE_MORE) ? ACT_READ_REMAINDER
                                                                  : ACT_NONE;
        if (pkt_open) begin
          r = blank_result(KIND_SUMMARY, 1'b0);
          if (is_point_report()) begin
            cnt = records_in_packet();
            if (cnt > POINT_LIMIT) cnt = POINT_LIMIT;
            r.word.count = cnt[3:0];
            if (first_pt[31:24] != 0 && !pen_is_down) begin
              pen_is_down = 1'b1;
              r.word.pen = PEN_DOWN;
              r.word.event_x = first_pt[11:0];
              r.word.event_y = first_pt[23:12];
            end else if (first_pt[31:24] == 0 && pen_is_down) begin
              pen_is_down = 1'b0;
              r.word.pen = PEN_UP;
              r.word.event_x = first_pt[11:0];
              r.word.event_y = first_pt[23:12];
            end
          end else if (first_id == ID_GESTURE && ge_flag) begin
            // A gesture lifts the pen without reporting an event.
            pen_is_down = 1'b0;
            r.word.gesture = gest;
          end
          pkt_open = 1'b0;
          if (keep) pending_results.push_back(r);
        end
        if (keep) pending_results.push_back(action_result(act));
      end
      default: ;
    endcase
  endtask

  // Offers one item, waits for its handshake and then updates the predictor; a typed item queues its planned action.
  task automatic send_item(input logic [1:0] op, input logic [IN_DATA_W-1:0] data,
                           input bit typed, input trd_action_t act, output bit used);
    int gap;
    bit took;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    decode_item(op, data, !typed, used);
    if (typed) pending_results.push_back(action_result(act));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    bit used;
    send_item(2'($urandom_range(0, 3)), {8'($urandom()), 32'($urandom())}, 1'b0, ACT_NONE,
              used);
    random_used += used;
  endtask

  // Mostly well-formed report transactions: status word, packet bytes, done byte.
  task automatic send_packet();
    int          kind, plen, nsend, r;
    logic [7:0]  lo, hi, id, b;
    logic [15:0] len;
    bit          used;
    kind = $urandom_range(0, 9);
    lo = 8'($urandom());
    hi = 8'($urandom());
    if (kind < 6) begin
      lo[LO_POINT] = 1'b1;
      id = 8'($urandom_range(0, 10));
    end else if (kind < 8) begin
      lo[LO_GEST] = 1'b1;
      id = ID_GESTURE;
    end else begin
      id = 8'($urandom());
    end
    if ($urandom_range(0, 9) != 0) begin
      hi[HI_BIOS] = 1'b0;
      hi[HI_CPU] = 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) len = 16'($urandom_range(4, 64));
    else if (r < 80) len = 16'($urandom_range(0, 3));
    else if (r < 92) len = 16'($urandom_range(65, 65535));
    else len = 16'($urandom());
    send_item(OP_STATUS, {8'($urandom()), len, hi, lo}, 1'b0, ACT_NONE, used);
    random_used += used;
    plen = (len > 64) ? 64 : int'(len);
    r = $urandom_range(0, 99);
    if (r < 80) nsend = plen;
    else if (r < 90) nsend = $urandom_range(0, plen);
    else nsend = plen + $urandom_range(1, 3);
    for (int k = 0; k < nsend; k++) begin
      b = 8'($urandom());
      if (k == 4) b = id;
      // Zero weights now and then so that the pen also goes up.
      if (k >= 4 && (k - 4) % 6 == 4 && $urandom_range(0, 2) == 0) b = 8'h00;
      if ($urandom_range(0, 49) == 0) begin
        send_item(OP_UNUSED, {8'($urandom()), 32'($urandom())}, 1'b0, ACT_NONE, used);
      end
      send_item(OP_REPORT, {b, 32'($urandom())}, 1'b0, ACT_NONE, used);
      random_used += used;
    end
    if ($urandom_range(0, 9) != 0) begin
      r = $urandom_range(0, 99);
      b = (r < 45) ? DONE_FINISHED : (r < 80) ? DONE_MORE : 8'($urandom());
      send_item(OP_DONE, {8'($urandom()), 16'($urandom()), 8'($urandom()), b}, 1'b0,
                ACT_NONE, used);
      random_used += used;
    end
  endtask

  task automatic compare_field(input string name, input longint unsigned e,
                               input longint unsigned a);
    if (e != a) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  task automatic check_result();
    decoded_t     e;
    result_word_t w;
    w = out_tdata;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result with no expectation, kind %0d data %h", $time, out_tuser,
               out_tdata);
      errors++;
    end else begin
      e = pending_results.pop_front();
      compare_field("result_kind", e.kind, out_tuser);
      compare_field("action", e.word.action, w.action);
      compare_field("point_id", e.word.pid, w.pid);
      compare_field("point_x", e.word.px, w.px);
      compare_field("point_y", e.word.py, w.py);
      compare_field("point_weight", e.word.weight, w.weight);
      compare_field("touch_count", e.word.count, w.count);
      compare_field("gesture_code", e.word.gesture, w.gesture);
      compare_field("pen_event", e.word.pen, w.pen);
      compare_field("event_x", e.word.event_x, w.event_x);
      compare_field("event_y", e.word.event_y, w.event_y);
      compare_field("zero bits", e.word.pad, w.pad);
      compare_field("last", e.last, out_tlast);
    end
  endtask

  // Handshake values are taken on the falling clock edge ahead of the edge that completes it.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  always begin : result_side
    int n;
    n = idle_len();
    if (n > 0) begin
      out_tready <= 1'b0;
      repeat (n) @(posedge clk);
    end
    out_tready <= 1'b1;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    bit used;
    plan = '{
      '{OP_DONE,   8'h82, 8'h00, 16'h0000, 8'h00, 1'b1, ACT_CLEAR},
      '{OP_DONE,   8'h00, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, ACT_READ_REMAINDER},
      '{OP_DONE,   8'h55, 8'h00, 16'h0000, 8'h00, 1'b1, ACT_NONE},
      '{OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, ACT_NONE},
      '{OP_STATUS, 8'h0B, 8'h68, 16'h0000, 8'h00, 1'b1, ACT_CPU_START},
      '{OP_STATUS, 8'h0B, 8'h28, 16'h0000, 8'h00, 1'b1, ACT_POINT_MODE},
      '{OP_STATUS, 8'h03, 8'h08, 16'h0000, 8'h00, 1'b1, ACT_CLEAR},
      '{OP_STATUS, 8'h08, 8'h08, 16'h0010, 8'h00, 1'b1, ACT_CLEAR},
      '{OP_STATUS, 8'h08, 8'h00, 16'h0010, 8'h00, 1'b1, ACT_NONE},
      '{OP_STATUS, 8'h01, 8'h97, 16'hFFFF, 8'h00, 1'b1, ACT_READ_REPORT},
      '{OP_DONE,   8'h82, 8'h00, 16'h0000, 8'h00, 1'b0, ACT_NONE},
      '{OP_STATUS, 8'h01, 8'h00, 16'd10,   8'h00, 1'b1, ACT_READ_REPORT},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'h0A, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hF0, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, ACT_NONE},
      '{OP_REPORT, 8'h00, 8'h00, 16'h0000, 8'hA5, 1'b0, ACT_NONE},
      '{OP_DONE,   8'h82, 8'h00, 16'h0000, 8'h00, 1'b0, ACT_NONE}
    };
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_item(plan[i].op, {plan[i].rbyte, plan[i].len, plan[i].hi, plan[i].lo},
                plan[i].typed, plan[i].act, used);
    end
    in_tvalid <= 1'b0;
    wait_drained();

    while (random_used < RANDOM_ITEMS) begin
      steady = (random_used >= 600 && random_used < 800);
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_packet();
      if ($urandom_range(0, 19) == 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
